/* sv/rkpd_pkg.sv */
// shared types and control codes for the rotating key parity decoder
package rkpd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_POS
  } state_e;

  typedef enum logic [1:0] {
    SEL_INDEX,
    SEL_SUM,
    SEL_POS
  } op_sel_e;

  typedef struct packed {
    op_sel_e sel;
    logic    start;
    logic    mem_re;
    logic    sum_we;
    logic    pos_we;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic we;
    logic re;
    logic wdata;
  } key_req_t;

endpackage

/* sv/rkpd_modadd.sv */
// shared modular adder: (a + b) mod KEY_BITS for operands below KEY_BITS
module rkpd_modadd #(
  parameter int KEY_BITS = 1024
) (
  input  logic [$clog2(KEY_BITS)-1:0] a_i,
  input  logic [$clog2(KEY_BITS)-1:0] b_i,
  output logic [$clog2(KEY_BITS)-1:0] r_o
);
  localparam int PW = $clog2(KEY_BITS);

  logic [PW:0] sum;
  logic [PW:0] red;

  always_comb begin
    sum = {1'b0, a_i} + {1'b0, b_i};
    red = sum - (PW+1)'(KEY_BITS);
    r_o = (sum >= (PW+1)'(KEY_BITS)) ? red[PW-1:0] : sum[PW-1:0];
  end

endmodule

/* sv/rkpd_keymem.sv */
// single port key store, one bit per entry, registered read
module rkpd_keymem #(
  parameter int KEY_BITS = 1024
) (
  input  logic                        clk_i,
  input  rkpd_pkg::key_req_t          req_i,
  input  logic [$clog2(KEY_BITS)-1:0] addr_i,
  output logic                        rdata_o
);
  logic mem [KEY_BITS];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr_i] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rkpd_core.sv */
// sequencer and datapath: walks the rotations through the shared adder and key store
module rkpd_core #(
  parameter int KEY_BITS   = 1024,
  parameter int BLOCK_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [9:0] start_q_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [9:0] key_address_i,
  input  logic       key_bit_i,
  input  logic [7:0] cipher_block_i,
  input  logic       first_block_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       plain_bit_o
);
  localparam int PW = $clog2(KEY_BITS);
  localparam int CW = $clog2(BLOCK_BITS);
  localparam int WW = ((PW > 10) ? PW : 10) + 1;

  rkpd_pkg::state_e   state_q, state_d;
  rkpd_pkg::ctl_t     ctl;
  rkpd_pkg::key_req_t req;

  logic [CW-1:0]         cnt_q;
  logic [CW-1:0]         rd_idx_q;
  logic                  rd_vld_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic [BLOCK_BITS-1:0] mask_q;
  logic                  par_q;
  logic [PW-1:0]         sum_q;
  logic [PW-1:0]         pos_q;
  logic                  out_vld_q;
  logic                  plain_q;

  logic                  accept;
  logic                  out_free;
  logic [PW-1:0]         unit_a, unit_b, unit_r;
  logic [PW-1:0]         waddr;
  logic [PW-1:0]         mem_addr;
  logic                  key_rd;
  logic                  z;
  logic [BLOCK_BITS-1:0] rot;

  // reduce a 10-bit value modulo KEY_BITS (KEY_BITS >= 256, so three steps at most)
  function automatic logic [PW-1:0] mod_key(input logic [9:0] v);
    logic [WW-1:0] r;
    r = WW'(v);
    for (int i = 0; i < 3; i++) begin
      if (r >= WW'(KEY_BITS)) begin
        r = r - WW'(KEY_BITS);
      end
    end
    return r[PW-1:0];
  endfunction

  function automatic logic [BLOCK_BITS-1:0] rotl(input logic [BLOCK_BITS-1:0] v,
                                                 input logic [CW-1:0] b);
    logic [2*BLOCK_BITS-1:0] t;
    t = {v, v} << b;
    return t[2*BLOCK_BITS-1:BLOCK_BITS];
  endfunction

  assign accept     = in_valid_i && (state_q == rkpd_pkg::ST_IDLE);
  assign in_stall_o = (state_q != rkpd_pkg::ST_IDLE);
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rkpd_pkg::ST_IDLE: begin
        if (accept && operation_i) begin
          state_d = rkpd_pkg::ST_READ;
        end
      end
      rkpd_pkg::ST_READ: begin
        if (cnt_q == CW'(BLOCK_BITS - 1)) begin
          state_d = rkpd_pkg::ST_SUM;
        end
      end
      rkpd_pkg::ST_SUM: begin
        state_d = rkpd_pkg::ST_POS;
      end
      rkpd_pkg::ST_POS: begin
        if (out_free) begin
          state_d = rkpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rkpd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.sel      = rkpd_pkg::SEL_INDEX;
    case (state_q)
      rkpd_pkg::ST_IDLE: begin
        ctl.start = accept && operation_i;
      end
      rkpd_pkg::ST_READ: begin
        ctl.mem_re = 1'b1;
      end
      rkpd_pkg::ST_SUM: begin
        ctl.sel    = rkpd_pkg::SEL_SUM;
        ctl.sum_we = 1'b1;
      end
      rkpd_pkg::ST_POS: begin
        ctl.sel      = rkpd_pkg::SEL_POS;
        ctl.pos_we   = out_free;
        ctl.out_load = out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign rot = rotl(blk_q, cnt_q);

  always_comb begin
    case (ctl.sel)
      rkpd_pkg::SEL_SUM: begin
        unit_a = sum_q;
        unit_b = PW'(blk_q);
      end
      rkpd_pkg::SEL_POS: begin
        unit_a = pos_q;
        unit_b = sum_q;
      end
      default: begin
        unit_a = pos_q;
        unit_b = PW'(rot);
      end
    endcase
  end

  rkpd_modadd #(
    .KEY_BITS(KEY_BITS)
  ) u_modadd (
    .a_i(unit_a),
    .b_i(unit_b),
    .r_o(unit_r)
  );

  assign waddr     = mod_key(key_address_i);
  assign req.we    = accept && !operation_i;
  assign req.re    = ctl.mem_re;
  assign req.wdata = key_bit_i;
  assign mem_addr  = ctl.mem_re ? unit_r : waddr;

  rkpd_keymem #(
    .KEY_BITS(KEY_BITS)
  ) u_keymem (
    .clk_i  (clk_i),
    .req_i  (req),
    .addr_i (mem_addr),
    .rdata_o(key_rd)
  );

  assign z = key_rd ^ mask_q[rd_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rkpd_pkg::ST_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      mask_q    <= '0;
      sum_q     <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ctl.mem_re;
      if (ctl.start) begin
        cnt_q <= '0;
      end else if (ctl.mem_re) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctl.start && first_block_i) begin
        mask_q <= '0;
      end else if (rd_vld_q) begin
        mask_q[rd_idx_q] <= z;
      end
      if (ctl.start && first_block_i) begin
        sum_q <= '0;
      end else if (ctl.sum_we) begin
        sum_q <= unit_r;
      end
      if (ctl.start && first_block_i) begin
        pos_q <= mod_key(start_q_i);
      end else if (ctl.pos_we) begin
        pos_q <= unit_r;
      end
      if (ctl.out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (ctl.start) begin
      blk_q <= cipher_block_i[BLOCK_BITS-1:0];
      par_q <= 1'b0;
    end else if (rd_vld_q) begin
      par_q <= par_q ^ z;
    end
    if (ctl.out_load) begin
      plain_q <= par_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign plain_bit_o = plain_q;

endmodule

/* sv/rotating_key_parity_decoder_unit.sv */
// top level of the rotating key parity decoder
//
//  channel   direction  handshake                  payload
//  config    in         cfg_we_i                   cfg_wdata_i (start position)
//  request   in         in_valid_i / in_stall_o    operation, key_address, key_bit,
//                                                  cipher_block, first_block
//  result    out        out_valid_o / out_stall_i  plain_bit
//
//  key write: the key store is written at the accepting edge
//  decode: one key store read per rotation through the
//  single port key memory, then a running sum step and a position step
//  one decode at a time; the result register frees the core while it waits
//  reset clears mask, sum, position and start; the key store is undefined until written
//  a held result stalls only the final step of the next decode
module rotating_key_parity_decoder_unit #(
  parameter int KEY_BITS   = 1024,
  parameter int BLOCK_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [9:0] key_address_i,
  input  logic       key_bit_i,
  input  logic [7:0] cipher_block_i,
  input  logic       first_block_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       plain_bit_o
);
  logic [9:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
    end
  end

  rkpd_core #(
    .KEY_BITS  (KEY_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_q_i     (start_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .key_address_i (key_address_i),
    .key_bit_i     (key_bit_i),
    .cipher_block_i(cipher_block_i),
    .first_block_i (first_block_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .plain_bit_o   (plain_bit_o)
  );

endmodule

/* sv/rkpd_checker.sv */
// port level checks for the rotating key parity decoder, bound to the top level
module rkpd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic operation_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic plain_bit_o
);
  logic dec_acc;
  logic wr_acc;

  assign dec_acc = in_valid_i && !in_stall_o && operation_i;
  assign wr_acc  = in_valid_i && !in_stall_o && !operation_i;

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(plain_bit_o))
    else $error("result dropped or changed while stalled");

  // a decode keeps the core busy after it is accepted
  a_dec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !$past(dec_acc, 1) && !$past(dec_acc, 2) && !$past(dec_acc, 3))
    else $error("core free too soon after a decode");

  // a key write does not leave the core busy
  a_wr_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_acc |=> !in_stall_o)
    else $error("key write left the core busy");

  // a new result only comes out of a busy core
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a decode in flight");

endmodule

bind rotating_key_parity_decoder_unit rkpd_checker u_rkpd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .operation_i(operation_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .plain_bit_o(plain_bit_o)
);

/* test/testbench.sv */
// testbench for the rotating key parity decoder: random and directed requests
`timescale 1ns / 1ps

module testbench;

  localparam int KEY_BITS = 1024;
  localparam int BLOCK_BITS = 8;
  localparam int SETTLE_CYCLES = 30;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TRAFFIC_ITEMS = 140;
  localparam logic OP_KEY_WRITE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  class parity_predictor;
    bit [KEY_BITS-1:0] key_bits;
    logic [BLOCK_BITS-1:0] chain_mask;
    logic [9:0] block_sum;
    logic [9:0] key_pos;
    logic [9:0] start_pos;
    logic expected_plain_bits[$];
    int failures;

    function new();
      key_bits = '0;
      chain_mask = '0;
      block_sum = '0;
      key_pos = '0;
      start_pos = '0;
      failures = 0;
    endfunction

    function void set_start(logic [9:0] value);
      start_pos = value;
    endfunction

    function int pending();
      return expected_plain_bits.size();
    endfunction

    function void note_request(logic op, logic [9:0] addr, logic kbit, logic [7:0] blk,
                               logic first);
      logic [15:0] doubled;
      logic [7:0] rotated;
      logic [9:0] idx;
      logic [BLOCK_BITS-1:0] fresh_mask;
      if (op == OP_KEY_WRITE) begin
        key_bits[addr] = kbit;
        return;
      end
      if (first) begin
        chain_mask = '0;
        block_sum = '0;
        key_pos = start_pos;
      end
      doubled = {blk, blk};
      for (int b = 0; b < BLOCK_BITS; b++) begin
        rotated = doubled[15-b -: 8];
        idx = key_pos + 10'(rotated);
        fresh_mask[b] = key_bits[idx] ^ chain_mask[b];
      end
      chain_mask = fresh_mask;
      block_sum = block_sum + 10'(blk);
      key_pos = key_pos + block_sum;
      expected_plain_bits.push_back(^fresh_mask);
    endfunction

    function void check_result(logic actual);
      logic want;
      if (expected_plain_bits.size() == 0) begin
        $error("plain_bit: expected nothing, actual %0b", actual);
        failures++;
        return;
      end
      want = expected_plain_bits.pop_front();
      if (actual !== want) begin
        $error("plain_bit: expected %0b, actual %0b", want, actual);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [9:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = OP_KEY_WRITE;
  logic [9:0] key_address_i = '0;
  logic key_bit_i = 1'b0;
  logic [7:0] cipher_block_i = '0;
  logic first_block_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic plain_bit_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold_request = 1'b0;
  parity_predictor predictor;

  rotating_key_parity_decoder_unit #(
    .KEY_BITS(KEY_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operation_i(operation_i),
    .key_address_i(key_address_i),
    .key_bit_i(key_bit_i),
    .cipher_block_i(cipher_block_i),
    .first_block_i(first_block_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .plain_bit_o(plain_bit_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      predictor.check_result(plain_bit_o);
    end
  end

  task automatic push_request(logic op, logic [9:0] addr, logic kbit, logic [7:0] blk,
                              logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    key_address_i <= addr;
    key_bit_i <= kbit;
    cipher_block_i <= blk;
    first_block_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predictor.note_request(op, addr, kbit, blk, first);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic change_start(logic [9:0] value);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    predictor.set_start(value);
  endtask

  task automatic run_traffic(int count);
    int done;
    int kind;
    int chain_len;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        chain_len = $urandom_range(12, 1);
        push_request(OP_DECODE, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'b1);
        repeat (chain_len) begin
          push_request(OP_DECODE, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                       8'($urandom_range(255)), 1'b0);
        end
        done += chain_len + 1;
      end else if (kind < 92) begin
        push_request(OP_KEY_WRITE, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
        done++;
      end else begin
        push_request(OP_DECODE, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'($urandom_range(1)));
        done++;
      end
    end
  endtask

  initial begin
    predictor = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    change_start(10'd1023);

    // fill the whole key store so no decode reads an unwritten entry
    for (int a = 0; a < KEY_BITS; a++) begin
      push_request(OP_KEY_WRITE, 10'(a), 1'($urandom_range(1)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
    end

    push_request(OP_DECODE, 10'd0, 1'b0, 8'h00, 1'b1);
    push_request(OP_DECODE, 10'd1023, 1'b1, 8'hff, 1'b0);
    push_request(OP_DECODE, 10'd0, 1'b0, 8'h80, 1'b0);
    push_request(OP_DECODE, 10'd0, 1'b0, 8'h01, 1'b0);
    push_request(OP_DECODE, 10'd0, 1'b0, 8'haa, 1'b0);
    push_request(OP_DECODE, 10'd0, 1'b0, 8'h55, 1'b0);
    push_request(OP_KEY_WRITE, 10'd0, 1'b1, 8'hff, 1'b1);
    push_request(OP_KEY_WRITE, 10'd1023, 1'b0, 8'h00, 1'b0);
    push_request(OP_KEY_WRITE, 10'd1023, 1'b1, 8'hff, 1'b1);
    push_request(OP_DECODE, 10'd0, 1'b0, 8'hff, 1'b1);
    push_request(OP_DECODE, 10'd1023, 1'b1, 8'h7f, 1'b0);
    push_request(OP_DECODE, 10'd1023, 1'b1, 8'hfe, 1'b0);
    push_request(OP_DECODE, 10'd0, 1'b0, 8'h00, 1'b1);
    push_request(OP_DECODE, 10'd0, 1'b0, 8'h00, 1'b1);
    push_request(OP_KEY_WRITE, 10'd512, 1'b1, 8'h00, 1'b0);
    push_request(OP_DECODE, 10'd512, 1'b1, 8'hff, 1'b0);

    change_start(10'd0);
    run_traffic(TRAFFIC_ITEMS);

    change_start(10'd1023);
    send_idle_pct = 88;
    run_traffic(TRAFFIC_ITEMS);

    change_start(10'($urandom_range(1023)));
    send_idle_pct = 0;
    recv_stall_pct = 88;
    run_traffic(TRAFFIC_ITEMS);

    change_start(10'd1);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    run_traffic(TRAFFIC_ITEMS);

    change_start(10'($urandom_range(1023)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_request = 1'b1;
    run_traffic(TRAFFIC_ITEMS);

    quiesce();
    if (predictor.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
